// ----- hdl/oedm_pkg.sv -----
// Package with the shared types and constants of the one-edit dictionary match core.
`default_nettype none
package oedm_pkg;
   localparam int DictDepth  = 1024;
   localparam int MaxLen     = 15;
   localparam int MaxMatches = 63;
   localparam int CntW   = $clog2(DictDepth + 1);
   localparam int IdxW   = $clog2(DictDepth);
   localparam int PosW   = $clog2(MaxLen + 1);
   localparam int CharW  = $clog2(MaxLen);
   localparam int AddrW  = $clog2(DictDepth * MaxLen);
   localparam int McntW  = $clog2(MaxMatches + 1);
   localparam int MidxW  = (MaxMatches > 1) ? $clog2(MaxMatches) : 1;

   localparam logic [1:0] ACT_DICT  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [1:0] KIND_MATCH   = 2'd0;
   localparam logic [1:0] KIND_VERDICT = 2'd1;
   localparam logic [1:0] KIND_LOAD    = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_TRUNC = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] ch;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  entry_index;
      logic        is_correct;
      logic        overflow;
      logic [1:0]  status;
      logic        end_of_run;
   } rsp_type;
endpackage
`default_nettype wire

// ----- hdl/oedm_queue.sv -----
// Two-entry command queue between the front and the back part.
`default_nettype none
module oedm_queue
   import oedm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         empty
);
   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rp_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wp_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ----- hdl/oedm_engine.sv -----
// Back part: dictionary storage, query buffer, entry scan and result output.
`default_nettype none
module oedm_engine
   import oedm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  cmd_type   cmd,
   input  wire logic cmd_valid,
   output logic      cmd_take,
   output rsp_type   rsp,
   output logic      rsp_valid,
   input  wire logic rsp_taken
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LEN   = 6'b000010,
      S_CMP   = 6'b000100,
      S_NEXT  = 6'b001000,
      S_EMIT  = 6'b010000,
      S_VERD  = 6'b100000
   } state_type;

   // Length relation between the query and the entry under comparison.
   typedef enum logic [1:0] {
      MODE_EQ    = 2'd0,
      MODE_QLONG = 2'd1,
      MODE_DLONG = 2'd2,
      MODE_FAR   = 2'd3
   } mode_type;

   logic [7:0]       chars_mem [DictDepth * MaxLen];
   logic [PosW-1:0]  len_mem [DictDepth];
   logic [IdxW-1:0]  mbuf_mem [MaxMatches];
   logic [7:0]       query_ff [MaxLen];

   state_type        state_ff, state_in;
   logic [CntW-1:0]  count_ff;
   logic [PosW-1:0]  lpos_ff, qlen_ff;
   logic             trunc_ff;
   logic [McntW-1:0] mcnt_ff, ecnt_ff;
   logic             ovf_ff, corr_ff;
   logic [1:0]       vst_ff;
   logic [CntW-1:0]  ent_ff;
   logic [AddrW-1:0] base_ff;
   logic [PosW-1:0]  dl_ff, i_ff, j_ff;
   logic             diff_ff;
   mode_type         mode_ff;
   logic [7:0]       rd_ff;
   logic             rd_ok_ff;
   logic [PosW-1:0]  len_rd_ff;
   logic [IdxW-1:0]  mb_rd_ff;
   rsp_type          out_ff;
   logic             out_v_ff;

   logic             out_free;
   logic [PosW-1:0]  dpos;
   logic [7:0]       qc;
   logic             dict_full;

   function automatic logic [AddrW-1:0] base_of(input logic [CntW-1:0] e);
      base_of = AddrW'(e * MaxLen);
   endfunction

   assign out_free  = !out_v_ff || rsp_taken;
   assign rsp       = out_ff;
   assign rsp_valid = out_v_ff;
   assign dict_full = (count_ff >= CntW'(DictDepth));
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid && out_free;

   // Dictionary index into the char memory follows the sequencing of i or j.
   always_comb begin
      dpos = (mode_ff == MODE_DLONG) ? i_ff : j_ff;
      qc   = query_ff[CharW'((mode_ff == MODE_DLONG) ? j_ff : i_ff)];
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: ;
         S_LEN:  state_in = S_CMP;
         S_CMP:  ;
         S_NEXT: state_in = S_LEN;
         S_EMIT: ;
         S_VERD: ;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         lpos_ff  <= '0;
         qlen_ff  <= '0;
         trunc_ff <= 1'b0;
         mcnt_ff  <= '0;
         out_v_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         logic out_set, rd_set;
         out_set = 1'b0;
         rd_set  = 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_take) begin
                  if (cmd.action == ACT_DICT) begin
                     if (dict_full) begin
                        if (cmd.last) begin
                           lpos_ff  <= '0;
                           trunc_ff <= 1'b0;
                           out_ff   <= '{KIND_LOAD, 10'd0, 1'b0, 1'b0, ST_FULL, 1'b1};
                           out_set  = 1'b1;
                        end
                     end else begin
                        if (lpos_ff < PosW'(MaxLen)) begin
                           chars_mem[base_of(count_ff) + AddrW'(lpos_ff)] <= cmd.ch;
                        end
                        if (cmd.last) begin
                           len_mem[count_ff[IdxW-1:0]] <=
                              (lpos_ff < PosW'(MaxLen)) ? lpos_ff + 1'b1 : lpos_ff;
                           count_ff <= count_ff + 1'b1;
                           lpos_ff  <= '0;
                           trunc_ff <= 1'b0;
                           out_ff   <= '{KIND_LOAD, 10'd0, 1'b0, 1'b0,
                              (trunc_ff || lpos_ff >= PosW'(MaxLen)) ? ST_TRUNC : ST_OK,
                              1'b1};
                           out_set  = 1'b1;
                        end else if (lpos_ff < PosW'(MaxLen)) begin
                           lpos_ff <= lpos_ff + 1'b1;
                        end else begin
                           trunc_ff <= 1'b1;
                        end
                     end
                  end else if (cmd.action == ACT_QUERY) begin
                     logic [PosW-1:0] nql;
                     logic            ntr;
                     nql = qlen_ff;
                     ntr = trunc_ff;
                     if (qlen_ff < PosW'(MaxLen)) begin
                        query_ff[CharW'(qlen_ff)] <= cmd.ch;
                        nql = qlen_ff + 1'b1;
                     end else begin
                        ntr = 1'b1;
                     end
                     qlen_ff  <= nql;
                     trunc_ff <= cmd.last ? 1'b0 : ntr;
                     if (cmd.last) begin
                        vst_ff   <= ntr ? ST_TRUNC : ST_OK;
                        mcnt_ff  <= '0;
                        ovf_ff   <= 1'b0;
                        corr_ff  <= 1'b0;
                        ent_ff   <= '0;
                        base_ff  <= '0;
                        state_ff <= (count_ff == '0) ? S_VERD : S_NEXT;
                     end
                  end else if (cmd.action == ACT_CLEAR) begin
                     count_ff <= '0;
                     lpos_ff  <= '0;
                     trunc_ff <= 1'b0;
                  end
               end
            end
            S_LEN: begin
               dl_ff    <= len_rd_ff;
               i_ff     <= '0;
               j_ff     <= '0;
               diff_ff  <= 1'b0;
               if (len_rd_ff == qlen_ff) mode_ff <= MODE_EQ;
               else if (qlen_ff == len_rd_ff + 1'b1) mode_ff <= MODE_QLONG;
               else if (len_rd_ff == qlen_ff + 1'b1) mode_ff <= MODE_DLONG;
               else mode_ff <= MODE_FAR;
               state_ff <= state_in;
            end
            S_CMP: begin
               // rd_ok marks that rd_ff holds the dictionary char at dpos.
               logic done, res_hit, res_exact;
               logic [PosW-1:0] ls, lt, ii, jj;
               done = 1'b0; res_hit = 1'b0; res_exact = 1'b0;
               ls = (mode_ff == MODE_DLONG) ? dl_ff : qlen_ff;
               lt = (mode_ff == MODE_DLONG) ? qlen_ff : dl_ff;
               ii = i_ff;
               jj = j_ff;
               if (mode_ff == MODE_FAR) begin
                  done = 1'b1;
               end else if (mode_ff == MODE_EQ) begin
                  if (i_ff == qlen_ff) begin
                     done = 1'b1; res_exact = !diff_ff; res_hit = diff_ff;
                  end else if (rd_ok_ff) begin
                     if (rd_ff != query_ff[CharW'(i_ff)]) begin
                        if (diff_ff) done = 1'b1;
                        diff_ff <= 1'b1;
                     end
                     i_ff <= i_ff + 1'b1;
                     j_ff <= j_ff + 1'b1;
                  end
               end else begin
                  if (ii == ls || jj == lt) begin
                     done = 1'b1; res_hit = 1'b1;
                  end else if (rd_ok_ff) begin
                     if (rd_ff != qc) begin
                        if (diff_ff) done = 1'b1;
                        diff_ff <= 1'b1;
                        i_ff <= i_ff + 1'b1;
                     end else begin
                        i_ff <= i_ff + 1'b1;
                        j_ff <= j_ff + 1'b1;
                     end
                  end
               end
               if (!done && !rd_ok_ff) begin
                  rd_set = 1'b1;
               end
               if (done) begin
                  if (res_exact) begin
                     corr_ff  <= 1'b1;
                     mcnt_ff  <= '0;
                     ovf_ff   <= 1'b0;
                     state_ff <= S_VERD;
                  end else begin
                     if (res_hit) begin
                        if (mcnt_ff < McntW'(MaxMatches)) begin
                           mbuf_mem[MidxW'(mcnt_ff)] <= ent_ff[IdxW-1:0];
                           mcnt_ff <= mcnt_ff + 1'b1;
                        end else begin
                           ovf_ff <= 1'b1;
                        end
                     end
                     if (ent_ff + 1'b1 == count_ff) begin
                        ecnt_ff  <= '0;
                        state_ff <= S_EMIT;
                     end else begin
                        ent_ff   <= ent_ff + 1'b1;
                        base_ff  <= base_ff + AddrW'(MaxLen);
                        state_ff <= S_NEXT;
                     end
                  end
               end
            end
            S_NEXT: state_ff <= state_in;
            S_EMIT: begin
               if (ecnt_ff == mcnt_ff) begin
                  state_ff <= S_VERD;
               end else if (rd_ok_ff && out_free) begin
                  out_ff   <= '{KIND_MATCH, 10'(mb_rd_ff), 1'b0, 1'b0, ST_OK, 1'b0};
                  out_set  = 1'b1;
                  ecnt_ff  <= ecnt_ff + 1'b1;
               end else if (!rd_ok_ff) begin
                  rd_set = 1'b1;
               end
            end
            S_VERD: begin
               if (out_free) begin
                  out_ff   <= '{KIND_VERDICT, 10'd0, corr_ff, ovf_ff, vst_ff, 1'b1};
                  out_set  = 1'b1;
                  qlen_ff  <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         out_v_ff <= out_set || (out_v_ff && !rsp_taken);
         rd_ok_ff <= rd_set;
      end
      rd_ff     <= chars_mem[base_ff + AddrW'(dpos)];
      len_rd_ff <= len_mem[ent_ff[IdxW-1:0]];
      mb_rd_ff  <= mbuf_mem[MidxW'(ecnt_ff)];
   end
endmodule
`default_nettype wire

// ----- hdl/one_edit_dictionary_match_core.sv -----
// Top level of the one-edit dictionary match core.
// Characters enter through a two-entry queue and the back part takes one per cycle while it is
// idle and its output register is free; a word's last character loads a status result, and
// input waits while a result is not yet popped. A query's last character starts a scan of the
// stored entries, with one read of the character store and one compare per character step; an
// exact match ends the scan at once. Otherwise the match indices then leave, each read from the
// match buffer and held while the output is not popped, followed by the verdict.
`default_nettype none
module one_edit_dictionary_match_core
   import oedm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_last,
   output logic            empty,
   input  wire logic       pop,
   output logic [1:0]      rsp_kind,
   output logic [9:0]      rsp_entry_index,
   output logic            rsp_is_correct,
   output logic            rsp_overflow,
   output logic [1:0]      rsp_status,
   output logic            rsp_end_of_run
);
   cmd_type q_out;
   logic    q_empty, take, rv;
   rsp_type r;

   oedm_queue u_queue (
      .clock, .reset, .push,
      .push_data('{req_action, req_ch, req_last}),
      .full, .pop(take), .pop_data(q_out), .empty(q_empty)
   );

   oedm_engine u_engine (
      .clock, .reset, .cmd(q_out), .cmd_valid(!q_empty), .cmd_take(take),
      .rsp(r), .rsp_valid(rv), .rsp_taken(pop && rv)
   );

   assign empty           = !rv;
   assign rsp_kind        = r.kind;
   assign rsp_entry_index = r.entry_index;
   assign rsp_is_correct  = r.is_correct;
   assign rsp_overflow    = r.overflow;
   assign rsp_status      = r.status;
   assign rsp_end_of_run  = r.end_of_run;
endmodule
`default_nettype wire
